>>> rtl/xsma_pkg.sv
// ----------------------------------------------------------------------------
// xsma_pkg
// Shared sizes for the x/y sample moving average.
// ----------------------------------------------------------------------------
package xsma_pkg;

	// deepest ring the block supports (window_size is clamped to this)
	localparam int unsigned MAX_WINDOW = 64;

	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CNT_W    = 7;
	localparam int unsigned SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	// running sum: one sample width plus the growth of a full window
	localparam int unsigned SUM_W    = SAMPLE_W + SLOT_W;
	localparam int unsigned ENTRY_W  = 2 * SAMPLE_W;

endpackage

>>> rtl/xsma_ram.sv
// ----------------------------------------------------------------------------
// xsma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xsma_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/xsma_div.sv
// ----------------------------------------------------------------------------
// xsma_div
// Two-lane iterative signed divider: running sums by the fill count,
// one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module xsma_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [xsma_pkg::SUM_W-1:0]   dividend_x,
	input  logic signed [xsma_pkg::SUM_W-1:0]   dividend_y,
	input  logic        [xsma_pkg::CNT_W-1:0]   divisor,
	output logic                                done,
	output logic signed [xsma_pkg::SAMPLE_W-1:0] quot_x,
	output logic signed [xsma_pkg::SAMPLE_W-1:0] quot_y
);

	import xsma_pkg::*;

	localparam int unsigned ITER_W = $clog2(SUM_W + 1);
	localparam int unsigned LAST   = SUM_W - 1;

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [SUM_W-1:0]  quo_q [2];
	logic [CNT_W-1:0]  rem_q [2];
	logic              neg_q [2];

	logic [SUM_W-1:0]  dvd_in [2];
	logic [SUM_W-1:0]  mag_in [2];
	logic [CNT_W:0]    trial  [2];
	logic              ge     [2];
	logic [CNT_W-1:0]  rem_nx [2];
	logic [SUM_W-1:0]  quo_nx [2];
	logic [SAMPLE_W-1:0] res  [2];

	assign dvd_in[0] = dividend_x;
	assign dvd_in[1] = dividend_y;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag_in[l] = dvd_in[l][SUM_W-1] ? (~dvd_in[l] + 1'b1) : dvd_in[l];
			// shift next dividend bit into the partial remainder
			trial[l]  = {rem_q[l], quo_q[l][SUM_W-1]};
			ge[l]     = (trial[l] >= {1'b0, dvs_q});
			rem_nx[l] = ge[l] ? CNT_W'(trial[l] - {1'b0, dvs_q}) : CNT_W'(trial[l]);
			quo_nx[l] = {quo_q[l][SUM_W-2:0], ge[l]};
			res[l]    = neg_q[l] ? (~quo_q[l][SAMPLE_W-1:0] + 1'b1)
			                     : quo_q[l][SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			for (int l = 0; l < 2; l++) begin
				quo_q[l] <= mag_in[l];
				rem_q[l] <= '0;
				neg_q[l] <= dvd_in[l][SUM_W-1];
			end
		end else if (busy_q) begin
			for (int l = 0; l < 2; l++) begin
				quo_q[l] <= quo_nx[l];
				rem_q[l] <= rem_nx[l];
			end
		end
	end

	assign done   = done_q;
	assign quot_x = res[0];
	assign quot_y = res[1];

endmodule

>>> rtl/xy_sample_moving_average.sv
// ----------------------------------------------------------------------------
// xy_sample_moving_average
// Two-channel moving average over the last window_size x/y sample pairs.
// ----------------------------------------------------------------------------
// Sequence: an add request passes through one read-modify-write, divider load,
//   22 divider steps, divider done and the output register; the last can wait
//   on out_stall. A clear request goes straight to the output register.
// Throughput: one request at a time; an add is paced by the bit-serial divider
//   (one quotient bit per cycle over the 22-bit sum).
// Reset: arst_n clears the history (empty window) and sets the window size to 64.
//   The sample store has no reset; only entries written since the last clear
//   are ever read back.
// ----------------------------------------------------------------------------
module xy_sample_moving_average (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic signed [xsma_pkg::SAMPLE_W-1:0] sample_x,
	input  logic signed [xsma_pkg::SAMPLE_W-1:0] sample_y,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [xsma_pkg::SAMPLE_W-1:0] avg_x,
	output logic signed [xsma_pkg::SAMPLE_W-1:0] avg_y,
	output logic        [xsma_pkg::CNT_W-1:0]    sample_count,
	// window size register
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [xsma_pkg::CNT_W-1:0]    window_size
);

	import xsma_pkg::*;

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	localparam logic [CNT_W-1:0] WIN_MAX   = CNT_W'(MAX_WINDOW);
	localparam logic [CNT_W-1:0] WIN_RESET = (MAX_WINDOW < 64) ? WIN_MAX : CNT_W'(64);

	typedef enum logic [2:0] {
		S_IDLE,      // waiting for a request
		S_RMW,       // old entry is on the RAM output; update sums, write back
		S_DIV_START, // load the divider with the new sums
		S_DIV_WAIT,  // divider iterating
		S_FIN        // hand the result to the output register
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          window_q;
	logic [SLOT_W-1:0]         wr_slot_q;
	logic [CNT_W-1:0]          filled_q;
	logic signed [SUM_W-1:0]   sum_x_q;
	logic signed [SUM_W-1:0]   sum_y_q;

	// captured request
	logic [SLOT_W-1:0]         slot_q;
	logic                      full_q;
	logic [SAMPLE_W-1:0]       x_q;
	logic [SAMPLE_W-1:0]       y_q;
	logic                      res_zero_q;

	// output register
	logic                      out_valid_q;
	logic [SAMPLE_W-1:0]       avg_x_q;
	logic [SAMPLE_W-1:0]       avg_y_q;
	logic [CNT_W-1:0]          count_q;

	logic                      in_acc;
	logic                      cfg_acc;
	logic                      out_free;
	logic [SLOT_W-1:0]         slot_cur;
	logic [CNT_W-1:0]          slot_inc;
	logic [CNT_W-1:0]          cfg_clamped;

	logic                      ram_we;
	logic [ENTRY_W-1:0]        ram_rdata;
	logic signed [SUM_W-1:0]   old_x;
	logic signed [SUM_W-1:0]   old_y;
	logic signed [SUM_W-1:0]   sum_x_nx;
	logic signed [SUM_W-1:0]   sum_y_nx;

	logic                      div_start;
	logic                      div_done;
	logic signed [SAMPLE_W-1:0] div_qx;
	logic signed [SAMPLE_W-1:0] div_qy;

	// One request in flight; config is only taken while nothing is in work.
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || !out_stall;

	// Write slot is kept below the window; guard anyway against a shrunk window.
	assign slot_cur = (CNT_W'(wr_slot_q) >= window_q) ? '0 : wr_slot_q;
	assign slot_inc = CNT_W'(slot_q) + 1'b1;

	always_comb begin
		if (window_size == '0) begin
			cfg_clamped = CNT_W'(1);
		end else if (window_size > WIN_MAX) begin
			cfg_clamped = WIN_MAX;
		end else begin
			cfg_clamped = window_size;
		end
	end

	// Store entry: x in the low half, y in the high half.
	assign old_x = SUM_W'($signed(ram_rdata[SAMPLE_W-1:0]));
	assign old_y = SUM_W'($signed(ram_rdata[ENTRY_W-1:SAMPLE_W]));

	// Full ring: the pair being overwritten leaves the sums.
	always_comb begin
		sum_x_nx = sum_x_q + SUM_W'($signed(x_q));
		sum_y_nx = sum_y_q + SUM_W'($signed(y_q));
		if (full_q) begin
			sum_x_nx = sum_x_nx - old_x;
			sum_y_nx = sum_y_nx - old_y;
		end
	end

	assign ram_we    = (state_q == S_RMW);
	assign div_start = (state_q == S_DIV_START);

	xsma_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_WINDOW),
		.ADDR_W(SLOT_W)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata({y_q, x_q}),
		.re   (in_acc),
		.raddr(slot_cur),
		.rdata(ram_rdata)
	);

	xsma_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend_x(sum_x_q),
		.dividend_y(sum_y_q),
		.divisor   (filled_q),
		.done      (div_done),
		.quot_x    (div_qx),
		.quot_y    (div_qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			window_q    <= WIN_RESET;
			wr_slot_q   <= '0;
			filled_q    <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			out_valid_q <= 1'b0;
			res_zero_q  <= 1'b0;
			avg_x_q     <= '0;
			avg_y_q     <= '0;
			count_q     <= '0;
		end else begin
			// result taken downstream; in S_FIN a new one may replace it
			if (out_valid_q && !out_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_acc) begin
				// new window size also empties the history
				window_q  <= cfg_clamped;
				wr_slot_q <= '0;
				filled_q  <= '0;
				sum_x_q   <= '0;
				sum_y_q   <= '0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (req_type == REQ_CLEAR) begin
							wr_slot_q  <= '0;
							filled_q   <= '0;
							sum_x_q    <= '0;
							sum_y_q    <= '0;
							res_zero_q <= 1'b1;
							state_q    <= S_FIN;
						end else begin
							// REQ_ADD: old entry read is issued this cycle
							res_zero_q <= 1'b0;
							state_q    <= S_RMW;
						end
					end
				end
				S_RMW: begin
					sum_x_q   <= sum_x_nx;
					sum_y_q   <= sum_y_nx;
					wr_slot_q <= (slot_inc >= window_q) ? '0 : SLOT_W'(slot_inc);
					if (!full_q) begin
						filled_q <= filled_q + 1'b1;
					end
					state_q <= S_DIV_START;
				end
				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						avg_x_q     <= res_zero_q ? '0 : div_qx;
						avg_y_q     <= res_zero_q ? '0 : div_qy;
						count_q     <= res_zero_q ? '0 : filled_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture (no reset needed).
	always_ff @(posedge clk) begin
		if (in_acc && (req_type == REQ_ADD)) begin
			slot_q <= slot_cur;
			full_q <= (filled_q >= window_q);
			x_q    <= sample_x;
			y_q    <= sample_y;
		end
	end

	assign out_valid    = out_valid_q;
	assign avg_x        = avg_x_q;
	assign avg_y        = avg_y_q;
	assign sample_count = count_q;

endmodule

>>> dv/xy_sample_moving_average_tb.sv
// ----------------------------------------------------------------------------
// xy_sample_moving_average_tb
// Self-checking bench for the x/y moving average: a queue-fed request driver,
// a result monitor with random stall, and an in-bench ring/running-sum model
// that predicts avg_x, avg_y and sample_count for each request accepted.
// ----------------------------------------------------------------------------
module xy_sample_moving_average_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import xsma_pkg::*;

	typedef enum logic {
		REQ_ADD   = 1'b0,
		REQ_CLEAR = 1'b1
	} req_kind_e;

	typedef struct {
		req_kind_e                   kind;
		logic signed [SAMPLE_W-1:0] x;
		logic signed [SAMPLE_W-1:0] y;
	} stick_req_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] avg_x;
		logic signed [SAMPLE_W-1:0] avg_y;
		logic        [CNT_W-1:0]    count;
	} avg_result_t;

	// long receiver hold, tail wait after the last drain, quiet-cycle watchdog
	localparam int LONG_HOLD  = 300;
	localparam int DRAIN_TAIL = 40;
	localparam int IDLE_LIMIT = 2000;

	// window writes for the random phases; 0 and >64 check saturation
	localparam logic [CNT_W-1:0] WINDOW_PLAN [12] =
		'{7'd127, 7'd1, 7'd2, 7'd3, 7'd0, 7'd5, 7'd8, 7'd17, 7'd33, 7'd63, 7'd64, 7'd65};

	// ------------------------------------------------------------------------
	// DUT signals, all inputs known from time zero
	// ------------------------------------------------------------------------
	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic                       req_type     = REQ_ADD;
	logic signed [SAMPLE_W-1:0] sample_x     = '0;
	logic signed [SAMPLE_W-1:0] sample_y     = '0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic signed [SAMPLE_W-1:0] avg_x;
	logic signed [SAMPLE_W-1:0] avg_y;
	logic        [CNT_W-1:0]    sample_count;
	logic                       cfg_valid    = 1'b0;
	logic                       cfg_ready;
	logic        [CNT_W-1:0]    window_size  = '0;

	xy_sample_moving_average dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.avg_x        (avg_x),
		.avg_y        (avg_y),
		.sample_count (sample_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.window_size  (window_size)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------------
	stick_req_t  stick_reqs [$];   // requests waiting for the driver
	avg_result_t avg_due [$];      // predicted results, oldest first

	int send_gap_max = 3;          // per-request idle draw, 0 = back to back
	int recv_gap_max = 3;          // per-result stall draw
	int send_wait;
	int stall_wait;
	int hold_left;
	int holds_asked  = 0;          // bumped by stimulus, served by the monitor
	int holds_served = 0;
	int quiet_cycles = 0;
	int mismatches   = 0;

	stick_req_t  next_req;
	avg_result_t want;

	// model of the ring: per-channel sample copies and running sums
	logic signed [SAMPLE_W-1:0] ring_x [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] ring_y [MAX_WINDOW];
	int win_len   = MAX_WINDOW;
	int next_slot = 0;
	int held      = 0;
	int sum_x     = 0;
	int sum_y     = 0;

	// coverage tallies for the closing summary
	int adds_seen    = 0;
	int clears_seen  = 0;
	int evictions    = 0;
	int cfg_writes   = 0;
	int peak_fill    = 0;
	int results_seen = 0;

	// ------------------------------------------------------------------------
	// Window model
	// ------------------------------------------------------------------------
	function automatic void empty_ring();
		next_slot = 0;
		held      = 0;
		sum_x     = 0;
		sum_y     = 0;
	endfunction

	// register write: saturate to 1..MAX_WINDOW, history is dropped
	function automatic void take_window(input logic [CNT_W-1:0] value);
		if (value == 0)
			win_len = 1;
		else if (value > MAX_WINDOW)
			win_len = MAX_WINDOW;
		else
			win_len = value;
		empty_ring();
		cfg_writes++;
	endfunction

	// apply one accepted request and queue the result it must produce
	function automatic void advance_window(input logic kind,
	                                       input logic signed [SAMPLE_W-1:0] x,
	                                       input logic signed [SAMPLE_W-1:0] y);
		avg_result_t res;
		int slot;
		if (kind == REQ_CLEAR) begin
			empty_ring();
			clears_seen++;
		end else begin
			slot = (next_slot >= win_len) ? 0 : next_slot;
			// full ring: oldest pair leaves the sums before its slot is reused
			if (held >= win_len) begin
				sum_x -= ring_x[slot];
				sum_y -= ring_y[slot];
				evictions++;
			end else begin
				held++;
			end
			ring_x[slot] = x;
			ring_y[slot] = y;
			sum_x += x;
			sum_y += y;
			slot++;
			next_slot = (slot >= win_len) ? 0 : slot;
			adds_seen++;
			if (held > peak_fill)
				peak_fill = held;
		end
		// empty window answers zeros; division truncates toward zero
		if (held == 0) begin
			res.avg_x = '0;
			res.avg_y = '0;
			res.count = '0;
		end else begin
			res.avg_x = SAMPLE_W'(sum_x / held);
			res.avg_y = SAMPLE_W'(sum_y / held);
			res.count = CNT_W'(held);
		end
		avg_due.push_back(res);
	endfunction

	// ------------------------------------------------------------------------
	// Request driver: pops the queue, random gap between requests,
	// payload held steady while stalled
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_ADD;
			sample_x <= '0;
			sample_y <= '0;
			send_wait = 0;
		end else begin
			if (in_valid && !in_stall)
				advance_window(req_type, sample_x, sample_y);
			if (!in_valid || !in_stall) begin
				if (send_wait != 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (stick_reqs.size() != 0) begin
					next_req = stick_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= next_req.kind;
					sample_x <= next_req.x;
					sample_y <= next_req.y;
					send_wait = $urandom_range(0, send_gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: checks against the oldest prediction. After each
	// result a stall count is drawn; it runs down only while out_valid is
	// up, so the stall lands on the next result. A long hold request from
	// the stimulus overrides the random stall while it lasts.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_wait = 0;
			hold_left  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (avg_due.size() == 0) begin
					$error("unexpected result: avg_x %0d avg_y %0d sample_count %0d",
					       avg_x, avg_y, sample_count);
					mismatches++;
				end else begin
					want = avg_due.pop_front();
					if (avg_x !== want.avg_x) begin
						$error("avg_x: expected %0d, got %0d", want.avg_x, avg_x);
						mismatches++;
					end
					if (avg_y !== want.avg_y) begin
						$error("avg_y: expected %0d, got %0d", want.avg_y, avg_y);
						mismatches++;
					end
					if (sample_count !== want.count) begin
						$error("sample_count: expected %0d, got %0d",
						       want.count, sample_count);
						mismatches++;
					end
				end
				stall_wait = $urandom_range(0, recv_gap_max);
			end else if (out_valid && stall_wait != 0) begin
				stall_wait--;
			end
			if (holds_served != holds_asked) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end else if (hold_left != 0) begin
				hold_left--;
			end
			out_stall <= (hold_left != 0) || (stall_wait != 0);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long without any handshake on any channel
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				         IDLE_LIMIT, avg_due.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic queue_req(input req_kind_e kind,
	                         input logic signed [SAMPLE_W-1:0] x,
	                         input logic signed [SAMPLE_W-1:0] y);
		stick_req_t r;
		r.kind = kind;
		r.x    = x;
		r.y    = y;
		stick_reqs.push_back(r);
	endtask

	// sender pause: everything queued has gone in and come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (stick_reqs.size() != 0 || in_valid || avg_due.size() != 0);
	endtask

	// only called with the block idle
	task automatic write_window(input logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_valid   <= 1'b1;
		window_size <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		take_window(value);
	endtask

	// style 0 mixes, 1 leans to the positive rail, 2 to the negative rail
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int style);
		int v;
		case ($urandom_range(0, 9))
			0:       v = 32767;
			1:       v = -32768;
			2, 3:    v = int'($urandom_range(0, 200)) - 100;
			default: v = int'($urandom);
		endcase
		if (style == 1 && $urandom_range(0, 3) != 0)
			v = 32767 - int'($urandom_range(0, 15));
		else if (style == 2 && $urandom_range(0, 3) != 0)
			v = -32768 + int'($urandom_range(0, 15));
		return v[SAMPLE_W-1:0];
	endfunction

	// mostly adds, an occasional clear with junk samples
	task automatic random_burst(input int count, input int style);
		repeat (count) begin
			if ($urandom_range(0, 31) == 0)
				queue_req(REQ_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
			else
				queue_req(REQ_ADD, pick_sample(style), pick_sample(style));
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset window (64): clear on empty, rails, truncation of negatives
		queue_req(REQ_CLEAR, 16'sh5A5A, -16'sd1);
		queue_req(REQ_ADD, 16'sh7FFF, 16'sh8000);
		queue_req(REQ_ADD, 16'sh7FFF, 16'sh8000);
		queue_req(REQ_ADD, 16'sh8000, 16'sh7FFF);
		queue_req(REQ_ADD, -16'sd1, 16'sd1);
		queue_req(REQ_ADD, 16'sd0, 16'sd0);
		queue_req(REQ_ADD, 16'sh8000, 16'sh8000);
		queue_req(REQ_ADD, 16'sd1, -16'sd1);
		queue_req(REQ_CLEAR, -16'sd1, -16'sd1);
		queue_req(REQ_ADD, -16'sd5, 16'sd7);
		queue_req(REQ_ADD, 16'sd2, -16'sd2);
		wait_drained();

		// zero saturates to a one-slot window: every add replaces the last
		write_window(7'd0);
		@(negedge clk);
		queue_req(REQ_ADD, 16'sd100, -16'sd100);
		queue_req(REQ_ADD, 16'sh8000, 16'sh7FFF);
		queue_req(REQ_CLEAR, 16'sd9, 16'sd9);
		queue_req(REQ_ADD, 16'sd3, 16'sd3);
		wait_drained();

		// two slots: wrap and evict
		write_window(7'd2);
		@(negedge clk);
		queue_req(REQ_ADD, 16'sd10, -16'sd10);
		queue_req(REQ_ADD, -16'sd3, 16'sd4);
		queue_req(REQ_ADD, 16'sd7, 16'sd7);
		queue_req(REQ_ADD, 16'sh8000, 16'sh8000);
		queue_req(REQ_CLEAR, 16'sd0, 16'sd0);
		wait_drained();

		// random phases, one window setting each
		for (int p = 0; p <= $size(WINDOW_PLAN); p++) begin
			if (p == $size(WINDOW_PLAN))
				write_window(CNT_W'($urandom_range(1, 127)));
			else
				write_window(WINDOW_PLAN[p]);
			@(negedge clk);
			// every fourth phase runs with no idling on either side
			if (p % 4 == 3) begin
				send_gap_max = 0;
				recv_gap_max = 0;
			end else begin
				send_gap_max = 15;
				recv_gap_max = 15;
			end
			if (p == 5) begin
				// receiver holds off while the sender keeps offering requests
				send_gap_max = 0;
				random_burst(40, 0);
				holds_asked++;
				random_burst(100, 0);
			end else if (p == 8) begin
				// sender pauses mid phase until all results are back
				random_burst(70, p % 3);
				wait_drained();
				random_burst(70, p % 3);
			end else begin
				random_burst(140, p % 3);
			end
			wait_drained();
		end

		repeat (DRAIN_TAIL) @(posedge clk);
		if (avg_due.size() != 0) begin
			$error("%0d predicted results never arrived", avg_due.size());
			mismatches++;
		end
		$display("covered %0d adds, %0d clears, %0d window writes, %0d evictions, peak fill %0d",
		         adds_seen, clears_seen, cfg_writes, evictions, peak_fill);
		$display("checked %0d results, %0d field mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
